[sv/kmli_pkg.sv]
// ----------------------------------------------------------------------------
// kmli_pkg
// Shared types and constants for the layer reflectance/transmittance solver.
// ----------------------------------------------------------------------------
`default_nettype none

package kmli_pkg;

  localparam int LEVEL_W   = 8;
  localparam int Q15_W     = 16;
  localparam int NUM_W     = 40;   // dividend: up to 255 * 2^32
  localparam int DEN_W     = 18;   // divisor: up to 2 * 65025
  localparam int QUO_W     = 33;   // quotient: up to 2^32
  localparam int ROOT_W    = 17;   // square root of a 33-bit value
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_REM_W  = ROOT_W + 1;

  localparam logic [Q15_W-1:0] ONE_Q15    = 16'd32768;
  localparam logic [16:0]      FULL_SQ    = 17'd65025;
  localparam logic [DEN_W-1:0] TWO_FULL   = 18'd510;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_RATIO,
    MODE_SQRT
  } mode_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } stage_ctl_t;

endpackage

`default_nettype wire

[sv/kmli_if.sv]
// ----------------------------------------------------------------------------
// kmli_req_if / kmli_rsp_if
// Valid/ready channels for the input levels and the solved layer values.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmli_req_if;
  import kmli_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] before_level;
  logic [LEVEL_W-1:0] after_level;
  modport source (output valid, before_level, after_level, input ready);
  modport sink (input valid, before_level, after_level, output ready);
endinterface

interface kmli_rsp_if;
  import kmli_pkg::*;
  logic             valid;
  logic             ready;
  logic [Q15_W-1:0] reflectance;
  logic [Q15_W-1:0] transmittance;
  logic             reflect_overflow;
  logic             sum_overflow;
  modport source (output valid, reflectance, transmittance, reflect_overflow,
                  sum_overflow, input ready);
  modport sink (input valid, reflectance, transmittance, reflect_overflow,
                sum_overflow, output ready);
endinterface

`default_nettype wire

[sv/kubelka_munk_layer_invert_core.sv]
// ----------------------------------------------------------------------------
// kubelka_munk_layer_invert_core
// Solves one paint layer's reflectance and transmittance from two levels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one channel as before_level and after_level; rsp returns
//   reflectance and transmittance in unsigned Q1.15 plus two overshoot flags.
//   A transaction on req takes place when valid and ready are both high, and
//   likewise on rsp.
//   Throughput is one transaction per cycle while rsp is not stalled. The
//   path is one setup stage, a 33-stage divider (one quotient bit per stage),
//   a 17-stage square root (one root bit per stage) and the output register.
//   Every item passes through both the divider and the root; the mode that
//   travels with it picks which result reaches the output.
//   All stages advance together. While rsp holds a result that is not taken,
//   the whole pipeline holds and req.ready is low; nothing is lost or repeated.
//   Reset clears every valid bit at once; req.ready is high in the first
//   cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module kubelka_munk_layer_invert_core (
  input  wire logic clk,
  input  wire logic rst,
  kmli_req_if.sink  req,
  kmli_rsp_if.source rsp
);
  import kmli_pkg::*;

  logic en;

  // Setup stage.
  logic [LEVEL_W-1:0] a, b;
  logic [15:0]        prod;
  logic [DEN_W-1:0]   d_wide;
  logic [16:0]        d;
  logic [15:0]        rn;
  mode_t              mode_next;
  logic [NUM_W-1:0]   num_next;
  logic [DEN_W-1:0]   den_next;

  stage_ctl_t         s0_ctl;
  logic [NUM_W-1:0]   s0_num;
  logic [DEN_W-1:0]   s0_den;

  stage_ctl_t         div_ctl;
  logic [QUO_W-1:0]   div_quo;
  stage_ctl_t         sq_ctl;
  logic [ROOT_W-1:0]  sq_root;
  logic [Q15_W-1:0]   sq_pass;

  logic [ROOT_W:0]    half_root;
  logic [Q15_W-1:0]   r_next, t_next;

  logic               out_valid;
  logic [Q15_W-1:0]   out_r, out_t;

  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  assign a      = req.after_level;
  assign b      = req.before_level;
  assign prod   = a * b;
  // Only used when a > b, where the denominator stays positive.
  assign d_wide = {2'b00, prod} + {1'b0, FULL_SQ} - (DEN_W'(b) * TWO_FULL);
  assign d      = d_wide[16:0];
  assign rn     = 16'(16'(a - b) * 16'(FULL_LEVEL));

  always_comb begin
    mode_next = MODE_RATIO;
    num_next  = '0;
    den_next  = DEN_W'(1);
    if (b == '0) begin
      mode_next = MODE_RATIO;
      num_next  = {16'd0, a, 16'd0} + NUM_W'(FULL_LEVEL);
      den_next  = TWO_FULL;
    end else if (a == '0) begin
      mode_next = MODE_ZERO;
    end else if (a <= b) begin
      // The root of floor(2^32 a / b), halved with rounding, is the result.
      mode_next = MODE_SQRT;
      num_next  = {a, 32'd0};
      den_next  = DEN_W'(b);
    end else begin
      mode_next = MODE_RATIO;
      num_next  = {8'd0, rn, 16'd0} + NUM_W'(d);
      den_next  = {d, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ctl.valid <= 1'b0;
    end else if (en) begin
      s0_ctl.valid <= req.valid;
    end
    if (en) begin
      s0_ctl.mode <= mode_next;
      s0_num      <= num_next;
      s0_den      <= den_next;
    end
  end

  kmli_div_pipe u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (s0_ctl),
    .num     (s0_num),
    .den     (s0_den),
    .ctl_out (div_ctl),
    .quo     (div_quo)
  );

  kmli_sqrt_pipe u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (div_ctl),
    .rad     (div_quo),
    .ctl_out (sq_ctl),
    .root    (sq_root),
    .pass    (sq_pass)
  );

  assign half_root = ({1'b0, sq_root} + (ROOT_W+1)'(1)) >> 1;

  always_comb begin
    r_next = '0;
    t_next = '0;
    case (sq_ctl.mode)
      MODE_RATIO: begin
        r_next = sq_pass;
        t_next = ONE_Q15 - sq_pass;
      end
      MODE_SQRT: begin
        r_next = '0;
        t_next = (half_root > (ROOT_W+1)'(ONE_Q15)) ? ONE_Q15 : half_root[Q15_W-1:0];
      end
      default: begin
        r_next = '0;
        t_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= r_next;
      out_t <= t_next;
    end
  end

  // With 8-bit levels R never exceeds 1, and in the ratio mode R + T is exactly 1.
  assign rsp.valid            = out_valid;
  assign rsp.reflectance      = out_r;
  assign rsp.transmittance    = out_t;
  assign rsp.reflect_overflow = 1'b0;
  assign rsp.sum_overflow     = 1'b0;

endmodule

`default_nettype wire

[sv/kmli_div_pipe.sv]
// ----------------------------------------------------------------------------
// kmli_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kmli_div_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire kmli_pkg::stage_ctl_t      ctl_in,
  input  wire logic [kmli_pkg::NUM_W-1:0] num,
  input  wire logic [kmli_pkg::DEN_W-1:0] den,
  output kmli_pkg::stage_ctl_t           ctl_out,
  output logic [kmli_pkg::QUO_W-1:0]     quo
);
  import kmli_pkg::*;

  localparam int NS = QUO_W;

  stage_ctl_t       ctl_q [NS];
  logic [DEN_W-1:0] rem_q [NS];
  logic [QUO_W-1:0] w_q   [NS];
  logic [DEN_W-1:0] den_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    stage_ctl_t       ctl_src;
    logic [DEN_W-1:0] rem_src;
    logic [QUO_W-1:0] w_src;
    logic [DEN_W-1:0] den_src;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      // The quotient fits QUO_W bits, so the bits above it start below den.
      assign ctl_src = ctl_in;
      assign rem_src = {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]};
      assign w_src   = num[QUO_W-1:0];
      assign den_src = den;
    end else begin : g_next
      assign ctl_src = ctl_q[k-1];
      assign rem_src = rem_q[k-1];
      assign w_src   = w_q[k-1];
      assign den_src = den_q[k-1];
    end

    assign trial = {rem_src, w_src[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_src};
    assign diff  = trial - {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k].valid <= 1'b0;
      end else if (en) begin
        ctl_q[k].valid <= ctl_src.valid;
      end
      if (en) begin
        ctl_q[k].mode <= ctl_src.mode;
        rem_q[k]      <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        w_q[k]        <= {w_src[QUO_W-2:0], ge};
        den_q[k]      <= den_src;
      end
    end
  end

  assign ctl_out = ctl_q[NS-1];
  assign quo     = w_q[NS-1];

endmodule

`default_nettype wire

[sv/kmli_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// kmli_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kmli_sqrt_pipe (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire kmli_pkg::stage_ctl_t       ctl_in,
  input  wire logic [kmli_pkg::QUO_W-1:0] rad,
  output kmli_pkg::stage_ctl_t            ctl_out,
  output logic [kmli_pkg::ROOT_W-1:0]     root,
  output logic [kmli_pkg::Q15_W-1:0]      pass
);
  import kmli_pkg::*;

  localparam int NS = ROOT_W;

  stage_ctl_t          ctl_q  [NS];
  logic [SQ_REM_W-1:0] rem_q  [NS];
  logic [ROOT_W-1:0]   root_q [NS];
  logic [RAD_W-1:0]    rad_q  [NS];
  logic [Q15_W-1:0]    pass_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    stage_ctl_t          ctl_src;
    logic [SQ_REM_W-1:0] rem_src;
    logic [ROOT_W-1:0]   root_src;
    logic [RAD_W-1:0]    rad_src;
    logic [Q15_W-1:0]    pass_src;
    logic [SQ_REM_W+1:0] cur;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign ctl_src  = ctl_in;
      assign rem_src  = '0;
      assign root_src = '0;
      assign rad_src  = {{(RAD_W-QUO_W){1'b0}}, rad};
      assign pass_src = rad[Q15_W-1:0];
    end else begin : g_next
      assign ctl_src  = ctl_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign rad_src  = rad_q[k-1];
      assign pass_src = pass_q[k-1];
    end

    assign cur   = {rem_src, rad_src[RAD_W-1 -: 2]};
    assign trial = {{(SQ_REM_W-ROOT_W){1'b0}}, root_src, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k].valid <= 1'b0;
      end else if (en) begin
        ctl_q[k].valid <= ctl_src.valid;
      end
      if (en) begin
        ctl_q[k].mode <= ctl_src.mode;
        rem_q[k]      <= ge ? diff[SQ_REM_W-1:0] : cur[SQ_REM_W-1:0];
        root_q[k]     <= {root_src[ROOT_W-2:0], ge};
        rad_q[k]      <= {rad_src[RAD_W-3:0], 2'b00};
        pass_q[k]     <= pass_src;
      end
    end
  end

  assign ctl_out = ctl_q[NS-1];
  assign root    = root_q[NS-1];
  assign pass    = pass_q[NS-1];

endmodule

`default_nettype wire

[sv/kmli_checker.sv]
// ----------------------------------------------------------------------------
// kmli_checker
// Port-level checks on the layer solver, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module kmli_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] reflectance,
  input wire logic [15:0] transmittance,
  input wire logic        reflect_overflow,
  input wire logic        sum_overflow
);
  import kmli_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(reflectance)
      && $stable(transmittance))
    else $error("stalled result changed");

  // The whole pipeline holds while the output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("input accepted while output stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> reflectance <= ONE_Q15 && transmittance <= ONE_Q15)
    else $error("result above 1.0");

  // A nonzero reflectance only comes from the ratio path, where R + T is 1.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reflectance != '0 |->
      ({1'b0, reflectance} + {1'b0, transmittance}) == {1'b0, ONE_Q15})
    else $error("reflectance and transmittance do not sum to 1.0");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !reflect_overflow && !sum_overflow)
    else $error("overshoot flag raised");

endmodule

bind kubelka_munk_layer_invert_core kmli_checker u_kmli_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .reflectance      (rsp.reflectance),
  .transmittance    (rsp.transmittance),
  .reflect_overflow (rsp.reflect_overflow),
  .sum_overflow     (rsp.sum_overflow)
);

`default_nettype wire
